/* src/hcbd_pkg.sv */
// Shared types, constants and helpers for the chunked body decoder.
// No dependencies; the top level, the checker and the testbench use it.
package hcbd_pkg;

    localparam int MAX_HEX_DIGITS_DEF = 8;
    localparam int LENGTH_BITS_DEF    = 32;

    localparam int          CFG_ADDR_W     = 3;
    localparam int          CFG_DATA_W     = 32;
    localparam logic        REG_MAX_BODY   = 1'b0;
    localparam logic [31:0] MAX_BODY_RESET = 32'h0010_0000;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_MALFORMED = 2'd1;
    localparam logic [1:0] ST_TOO_LARGE = 2'd2;

    localparam logic [7:0] CH_CR = 8'h0D;
    localparam logic [7:0] CH_LF = 8'h0A;

    typedef enum logic [8:0] {
        PH_SIZE     = 9'b0_0000_0001,
        PH_SIZE_LF  = 9'b0_0000_0010,
        PH_DATA     = 9'b0_0000_0100,
        PH_DATA_CR  = 9'b0_0000_1000,
        PH_DATA_LF  = 9'b0_0001_0000,
        PH_TRAIL    = 9'b0_0010_0000,
        PH_TRAIL_LF = 9'b0_0100_0000,
        PH_DONE     = 9'b0_1000_0000,
        PH_ERROR    = 9'b1_0000_0000
    } t_phase;

    typedef struct packed {
        logic       ok;
        logic [3:0] val;
    } t_hex;

    function automatic t_hex hex_decode(input logic [7:0] b);
        t_hex h;
        h.ok  = 1'b1;
        h.val = 4'd0;
        if (b >= 8'h30 && b <= 8'h39) begin
            h.val = 4'(b - 8'h30);
        end else if (b >= 8'h61 && b <= 8'h66) begin
            h.val = 4'(b - 8'h57);
        end else if (b >= 8'h41 && b <= 8'h46) begin
            h.val = 4'(b - 8'h37);
        end else begin
            h.ok = 1'b0;
        end
        return h;
    endfunction

endpackage

/* src/hcbd_in_if.sv */
// Input channel of the chunked body decoder: one raw body byte per word.
// Depends on nothing.
interface hcbd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;

    modport source (output valid, output data_byte, input ready);
    modport sink   (input valid, input data_byte, output ready);
endinterface

/* src/hcbd_out_if.sv */
// Result channel of the chunked body decoder: one decoded result per word.
// Depends on nothing.
interface hcbd_out_if;
    logic       valid;
    logic       ready;
    logic       payload_valid;
    logic [7:0] payload_byte;
    logic       body_done;
    logic [1:0] status;

    modport source (output valid, output payload_valid, output payload_byte,
                    output body_done, output status, input ready);
    modport sink   (input valid, input payload_valid, input payload_byte,
                    input body_done, input status, output ready);
endinterface

/* src/http_chunked_body_decoder_unit.sv */
// Top level of the HTTP/1.1 chunked body decoder.
// Depends on hcbd_pkg, hcbd_in_if and hcbd_out_if.
//
//   Channel   Direction  Word contents
//   i_in      in         data_byte
//   o_out     out        payload_valid, payload_byte, body_done, status
//   APB       in/out     max_body_size at byte address 0
//
// One word is accepted per cycle unless the output stalls; the result is registered.
// The single parse stage between the input and the output register sets that rate.
// A new word is taken whenever the output register is empty or is being drained.
// Reset is synchronous and active low; it clears the parser and restores the size limit.
// Done and error are sticky until reset.
module http_chunked_body_decoder_unit #(
    parameter int MAX_HEX_DIGITS = hcbd_pkg::MAX_HEX_DIGITS_DEF,
    parameter int LENGTH_BITS    = hcbd_pkg::LENGTH_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    hcbd_in_if.sink                         i_in,
    hcbd_out_if.source                      o_out,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [hcbd_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [hcbd_pkg::CFG_DATA_W-1:0] pwdata,
    output logic [hcbd_pkg::CFG_DATA_W-1:0] prdata,
    output logic                            pready
);

    localparam int DC_W  = $clog2(MAX_HEX_DIGITS + 1);
    localparam int CMP_W = (LENGTH_BITS > 32) ? LENGTH_BITS : 32;

    hcbd_pkg::t_phase       r_phase, n_phase;
    logic [LENGTH_BITS-1:0] r_rem, n_rem;
    logic [LENGTH_BITS-1:0] r_count, n_count;
    logic [DC_W-1:0]        r_digits, n_digits;
    logic                   r_trail_empty, n_trail_empty;
    logic [1:0]             r_err, n_err;
    logic [31:0]            r_max;

    logic                   r_out_valid;
    logic                   r_out_pv, n_out_pv;
    logic [7:0]             r_out_pb, n_out_pb;
    logic                   r_out_done;
    logic [1:0]             r_out_status;

    logic                   in_accept;
    logic                   cfg_write;
    logic                   reg_sel;
    logic [7:0]             b;
    hcbd_pkg::t_hex         hex;
    logic [LENGTH_BITS-1:0] rem_dec;

    assign reg_sel   = paddr[hcbd_pkg::CFG_ADDR_W-1:2] == hcbd_pkg::REG_MAX_BODY;
    assign cfg_write = psel & penable & pwrite & pready;
    assign pready    = 1'b1;
    assign prdata    = reg_sel ? r_max : '0;

    assign i_in.ready = !r_out_valid || o_out.ready;
    assign in_accept  = i_in.valid && i_in.ready;
    assign b          = i_in.data_byte;
    assign hex        = hcbd_pkg::hex_decode(b);
    assign rem_dec    = (r_rem != '0) ? r_rem - 1'b1 : r_rem;

    always_comb begin
        n_phase       = r_phase;
        n_rem         = r_rem;
        n_count       = r_count;
        n_digits      = r_digits;
        n_trail_empty = r_trail_empty;
        n_err         = r_err;
        n_out_pv      = 1'b0;
        n_out_pb      = 8'd0;
        case (r_phase)
            hcbd_pkg::PH_SIZE: begin
                if (hex.ok) begin
                    if (r_digits >= DC_W'(MAX_HEX_DIGITS)) begin
                        n_err   = hcbd_pkg::ST_MALFORMED;
                        n_phase = hcbd_pkg::PH_ERROR;
                    end else if (|r_rem[LENGTH_BITS-1 -: 4]) begin
                        n_err   = hcbd_pkg::ST_TOO_LARGE;
                        n_phase = hcbd_pkg::PH_ERROR;
                    end else begin
                        n_rem    = {r_rem[LENGTH_BITS-5:0], hex.val};
                        n_digits = r_digits + 1'b1;
                    end
                end else if (b == hcbd_pkg::CH_CR && r_digits != '0) begin
                    n_phase = hcbd_pkg::PH_SIZE_LF;
                end else begin
                    n_err   = hcbd_pkg::ST_MALFORMED;
                    n_phase = hcbd_pkg::PH_ERROR;
                end
            end
            hcbd_pkg::PH_SIZE_LF: begin
                if (b != hcbd_pkg::CH_LF) begin
                    n_err   = hcbd_pkg::ST_MALFORMED;
                    n_phase = hcbd_pkg::PH_ERROR;
                end else if (r_rem == '0) begin
                    n_trail_empty = 1'b1;
                    n_phase       = hcbd_pkg::PH_TRAIL;
                end else begin
                    n_phase = hcbd_pkg::PH_DATA;
                end
            end
            hcbd_pkg::PH_DATA: begin
                n_out_pv = 1'b1;
                n_out_pb = b;
                if (r_count != '1) begin
                    n_count = r_count + 1'b1;
                end
                n_rem = rem_dec;
                if (rem_dec == '0) begin
                    n_phase = hcbd_pkg::PH_DATA_CR;
                end
            end
            hcbd_pkg::PH_DATA_CR: begin
                if (b == hcbd_pkg::CH_CR) begin
                    n_phase = hcbd_pkg::PH_DATA_LF;
                end else begin
                    n_err   = hcbd_pkg::ST_MALFORMED;
                    n_phase = hcbd_pkg::PH_ERROR;
                end
            end
            hcbd_pkg::PH_DATA_LF: begin
                if (b != hcbd_pkg::CH_LF) begin
                    n_err   = hcbd_pkg::ST_MALFORMED;
                    n_phase = hcbd_pkg::PH_ERROR;
                end else if (CMP_W'(r_count) > CMP_W'(r_max)) begin
                    n_err   = hcbd_pkg::ST_TOO_LARGE;
                    n_phase = hcbd_pkg::PH_ERROR;
                end else begin
                    n_digits = '0;
                    n_rem    = '0;
                    n_phase  = hcbd_pkg::PH_SIZE;
                end
            end
            hcbd_pkg::PH_TRAIL: begin
                if (b == hcbd_pkg::CH_CR) begin
                    n_phase = hcbd_pkg::PH_TRAIL_LF;
                end else begin
                    n_trail_empty = 1'b0;
                end
            end
            hcbd_pkg::PH_TRAIL_LF: begin
                if (b != hcbd_pkg::CH_LF) begin
                    n_err   = hcbd_pkg::ST_MALFORMED;
                    n_phase = hcbd_pkg::PH_ERROR;
                end else if (r_trail_empty) begin
                    n_phase = hcbd_pkg::PH_DONE;
                end else begin
                    n_trail_empty = 1'b1;
                    n_phase       = hcbd_pkg::PH_TRAIL;
                end
            end
            hcbd_pkg::PH_DONE: begin
                n_phase = hcbd_pkg::PH_DONE;
            end
            default: begin
                n_phase = hcbd_pkg::PH_ERROR;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= hcbd_pkg::PH_SIZE;
            r_rem         <= '0;
            r_count       <= '0;
            r_digits      <= '0;
            r_trail_empty <= 1'b1;
            r_err         <= hcbd_pkg::ST_OK;
            r_max         <= hcbd_pkg::MAX_BODY_RESET;
            r_out_valid   <= 1'b0;
        end else begin
            if (cfg_write && reg_sel) begin
                r_max <= pwdata;
            end
            if (in_accept) begin
                r_phase       <= n_phase;
                r_rem         <= n_rem;
                r_count       <= n_count;
                r_digits      <= n_digits;
                r_trail_empty <= n_trail_empty;
                r_err         <= n_err;
                r_out_valid   <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_out_pv     <= n_out_pv;
            r_out_pb     <= n_out_pb;
            r_out_done   <= n_phase == hcbd_pkg::PH_DONE;
            r_out_status <= (n_phase == hcbd_pkg::PH_ERROR) ? n_err : hcbd_pkg::ST_OK;
        end
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.payload_valid = r_out_pv;
    assign o_out.payload_byte  = r_out_pb;
    assign o_out.body_done     = r_out_done;
    assign o_out.status        = r_out_status;

endmodule

/* src/hcbd_checker.sv */
// Port-level checks for the chunked body decoder, bound to its top level.
// Depends on hcbd_pkg and http_chunked_body_decoder_unit.
module hcbd_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic       i_payload_valid,
    input logic [7:0] i_payload_byte,
    input logic       i_body_done,
    input logic [1:0] i_status
);

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_payload_valid)
            && $stable(i_payload_byte) && $stable(i_body_done) && $stable(i_status))
        else $error("Result word changed while stalled.");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("Result word shown right after reset.");

    a_payload_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_payload_valid |-> i_status == hcbd_pkg::ST_OK && !i_body_done)
        else $error("Payload byte reported together with done or error.");

    a_done_no_err: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_body_done |-> i_status == hcbd_pkg::ST_OK)
        else $error("Done reported together with an error.");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> i_status == hcbd_pkg::ST_OK || i_status == hcbd_pkg::ST_MALFORMED
            || i_status == hcbd_pkg::ST_TOO_LARGE)
        else $error("Unknown status code.");

endmodule

bind http_chunked_body_decoder_unit hcbd_checker u_hcbd_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_out_valid     (o_out.valid),
    .i_out_ready     (o_out.ready),
    .i_payload_valid (o_out.payload_valid),
    .i_payload_byte  (o_out.payload_byte),
    .i_body_done     (o_out.body_done),
    .i_status        (o_out.status)
);

/* tb/http_chunked_body_decoder_unit_tb.sv */
// Testbench for the HTTP chunked body decoder: a short directed word list with fixed results,
// then random bodies and an ending, checked by a model, with bursty input and result-side stalls.
// Depends on hcbd_pkg, hcbd_in_if, hcbd_out_if and http_chunked_body_decoder_unit.
module http_chunked_body_decoder_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import hcbd_pkg::*;

    localparam int      HEX_DIGITS       = MAX_HEX_DIGITS_DEF;
    localparam int      LEN_W            = LENGTH_BITS_DEF;
    localparam realtime CLK_HALF         = 6ns;
    localparam int      RESET_CYCLES     = 11;
    localparam int      IDLE_LIMIT       = 2000;
    localparam int      DRAIN_CYCLES     = 4;
    localparam int      RANDOM_PER_PHASE = 375;
    localparam int      IGNORED_TAIL     = 12;
    localparam int      N_DIRECTED       = 20;

    localparam logic [LEN_W-1:0]      LEN_MAX       = {LEN_W{1'b1}};
    localparam logic [CFG_ADDR_W-1:0] ADDR_MAX_BODY = CFG_ADDR_W'(4 * int'(REG_MAX_BODY));

    typedef struct packed {
        logic       pv;
        logic [7:0] pbyte;
        logic       done;
        logic [1:0] status;
    } t_result;

    typedef struct packed {
        logic [7:0] data;
        logic       fixed;
        t_result    result;
    } t_word;

    typedef enum int {
        END_DONE, END_BAD_DIGIT, END_EMPTY_SIZE, END_MANY_DIGITS, END_NO_SIZE_LF,
        END_NO_DATA_CR, END_NO_DATA_LF, END_TRAIL_NO_LF, END_TOO_LARGE
    } t_ending;

    typedef enum int {DRAIN_FREE, DRAIN_COIN, DRAIN_SPARSE, DRAIN_SLOW} t_drain;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [CFG_ADDR_W-1:0] paddr;
    logic [CFG_DATA_W-1:0] pwdata;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;

    hcbd_in_if  in_ch ();
    hcbd_out_if out_ch ();

    t_word offered;

    t_phase           m_phase;
    logic [LEN_W-1:0] m_remaining;
    logic [LEN_W-1:0] m_count;
    int               m_digits;
    logic             m_trail_empty;
    logic [1:0]       m_err;
    logic [31:0]      m_limit;

    t_result due_decodes [$];
    t_word   body_bytes [$];
    t_word   directed_rows [N_DIRECTED];

    int      failures = 0;
    int      bytes_in = 0;
    int      results_out = 0;
    int      payload_out = 0;
    int      chunks_planned = 0;
    int      burst_left = 0;
    int      idle_cycles = 0;
    int      stall_left = 0;
    t_drain  stall_mode = DRAIN_FREE;
    t_ending ending;

    http_chunked_body_decoder_unit uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #(CLK_HALF) i_clk = ~i_clk;

    function automatic int hex_nibble(input logic [7:0] c);
        if (c >= 8'h30 && c <= 8'h39) return int'(c) - 'h30;
        if (c >= 8'h61 && c <= 8'h66) return int'(c) - 'h57;
        if (c >= 8'h41 && c <= 8'h46) return int'(c) - 'h37;
        return -1;
    endfunction

    function automatic void enter_error(input logic [1:0] code);
        m_err   = code;
        m_phase = PH_ERROR;
    endfunction

    function automatic t_result decode_byte(input logic [7:0] b);
        t_result r;
        int      d;
        r = '0;
        d = hex_nibble(b);
        case (m_phase)
            PH_SIZE: begin
                if (d >= 0) begin
                    if (m_digits >= HEX_DIGITS) begin
                        enter_error(ST_MALFORMED);
                    end else if (m_remaining > (LEN_MAX >> 4)) begin
                        enter_error(ST_TOO_LARGE);
                    end else begin
                        m_remaining = {m_remaining[LEN_W-5:0], 4'(d)};
                        m_digits++;
                    end
                end else if (b == CH_CR && m_digits != 0) begin
                    m_phase = PH_SIZE_LF;
                end else begin
                    enter_error(ST_MALFORMED);
                end
            end
            PH_SIZE_LF: begin
                if (b != CH_LF) begin
                    enter_error(ST_MALFORMED);
                end else if (m_remaining == 0) begin
                    m_trail_empty = 1'b1;
                    m_phase       = PH_TRAIL;
                end else begin
                    m_phase = PH_DATA;
                end
            end
            PH_DATA: begin
                r.pv    = 1'b1;
                r.pbyte = b;
                if (m_count != LEN_MAX) m_count++;
                if (m_remaining != 0) m_remaining--;
                if (m_remaining == 0) m_phase = PH_DATA_CR;
            end
            PH_DATA_CR: begin
                if (b == CH_CR) m_phase = PH_DATA_LF;
                else enter_error(ST_MALFORMED);
            end
            PH_DATA_LF: begin
                if (b != CH_LF) begin
                    enter_error(ST_MALFORMED);
                end else if (m_count > m_limit) begin
                    enter_error(ST_TOO_LARGE);
                end else begin
                    m_digits    = 0;
                    m_remaining = '0;
                    m_phase     = PH_SIZE;
                end
            end
            PH_TRAIL: begin
                if (b == CH_CR) m_phase = PH_TRAIL_LF;
                else m_trail_empty = 1'b0;
            end
            PH_TRAIL_LF: begin
                if (b != CH_LF) begin
                    enter_error(ST_MALFORMED);
                end else if (m_trail_empty) begin
                    m_phase = PH_DONE;
                end else begin
                    m_trail_empty = 1'b1;
                    m_phase       = PH_TRAIL;
                end
            end
            PH_DONE: ;
            default: m_phase = PH_ERROR;
        endcase
        r.done   = (m_phase == PH_DONE);
        r.status = (m_phase == PH_ERROR) ? m_err : ST_OK;
        return r;
    endfunction

    function automatic void check_field(input string name, input logic [31:0] want, got);
        if (want !== got) begin
            $error("%s: expected %0h, actual %0h", name, want, got);
            failures++;
        end
    endfunction

    function automatic t_word fixed_row(input logic [7:0] d, input logic pv);
        t_word w;
        w.data   = d;
        w.fixed  = 1'b1;
        w.result = '{pv, pv ? d : 8'h00, 1'b0, ST_OK};
        return w;
    endfunction

    function automatic logic [7:0] hex_char(input int v);
        if (v < 10) return 8'h30 + 8'(v);
        if ($urandom_range(1)) return 8'h41 + 8'(v - 10);
        return 8'h61 + 8'(v - 10);
    endfunction

    function automatic logic [7:0] byte_other_than(input logic [7:0] avoid);
        logic [7:0] b;
        do b = 8'($urandom_range(255)); while (b == avoid);
        return b;
    endfunction

    task automatic plan_byte(input logic [7:0] b);
        t_word w;
        w      = '0;
        w.data = b;
        body_bytes = {body_bytes, w};
    endtask

    task automatic plan_size_line(input int unsigned size);
        int n;
        int pad;
        n = 1;
        while (n < HEX_DIGITS && (size >> (4 * n)) != 0) n++;
        pad = ($urandom_range(3) == 0) ? $urandom_range(HEX_DIGITS - n) : 0;
        repeat (pad) plan_byte(8'h30);
        for (int i = n - 1; i >= 0; i--) plan_byte(hex_char((size >> (4 * i)) & 15));
        plan_byte(CH_CR);
        plan_byte(CH_LF);
    endtask

    task automatic plan_chunk(input int unsigned size);
        plan_size_line(size);
        repeat (size) plan_byte(8'($urandom_range(255)));
        plan_byte(CH_CR);
        plan_byte(CH_LF);
        chunks_planned++;
    endtask

    task automatic plan_random_body(input int target);
        int          start;
        int unsigned pick;
        start = body_bytes.size();
        while (body_bytes.size() - start < target) begin
            pick = $urandom_range(99);
            if (pick < 70) plan_chunk($urandom_range(1, 8));
            else if (pick < 95) plan_chunk($urandom_range(9, 64));
            else plan_chunk($urandom_range(65, 400));
        end
    endtask

    task automatic plan_trailer_line();
        repeat ($urandom_range(1, 10)) begin
            if ($urandom_range(3) == 0) plan_byte(CH_LF);
            else plan_byte(byte_other_than(CH_CR));
        end
    endtask

    task automatic plan_ending();
        logic [7:0] b;
        int         size;
        case (ending)
            END_DONE: begin
                plan_size_line(0);
                repeat ($urandom_range(3)) begin
                    plan_trailer_line();
                    plan_byte(CH_CR);
                    plan_byte(CH_LF);
                end
                plan_byte(CH_CR);
                plan_byte(CH_LF);
            end
            END_BAD_DIGIT: begin
                repeat ($urandom_range(3)) plan_byte(hex_char($urandom_range(15)));
                do b = 8'($urandom_range(255)); while (hex_nibble(b) >= 0 || b == CH_CR);
                plan_byte(b);
            end
            END_EMPTY_SIZE: begin
                plan_byte(CH_CR);
                plan_byte(CH_LF);
            end
            END_MANY_DIGITS: begin
                repeat (HEX_DIGITS + 1) plan_byte(hex_char($urandom_range(15)));
            end
            END_NO_SIZE_LF: begin
                plan_byte(hex_char($urandom_range(1, 15)));
                plan_byte(CH_CR);
                plan_byte(byte_other_than(CH_LF));
            end
            END_NO_DATA_CR, END_NO_DATA_LF: begin
                size = $urandom_range(1, 4);
                plan_size_line(size);
                repeat (size) plan_byte(8'($urandom_range(255)));
                if (ending == END_NO_DATA_CR) begin
                    plan_byte(byte_other_than(CH_CR));
                end else begin
                    plan_byte(CH_CR);
                    plan_byte(byte_other_than(CH_LF));
                end
            end
            END_TRAIL_NO_LF: begin
                plan_size_line(0);
                if ($urandom_range(1)) plan_trailer_line();
                plan_byte(CH_CR);
                plan_byte(byte_other_than(CH_LF));
            end
            default: begin
                plan_chunk($urandom_range(1, 8));
            end
        endcase
        repeat (IGNORED_TAIL) plan_byte(8'($urandom_range(255)));
    endtask

    task automatic drive_plan();
        int gap;
        while (body_bytes.size() != 0) begin
            if (burst_left == 0) begin
                case ($urandom_range(9))
                    0, 1, 2, 3: gap = 0;
                    9:          gap = $urandom_range(8, 20);
                    default:    gap = $urandom_range(1, 5);
                endcase
                if (gap != 0) begin
                    in_ch.valid <= 1'b0;
                    repeat (gap) @(posedge i_clk);
                end
                burst_left = $urandom_range(1, 24);
            end
            in_ch.valid     <= 1'b1;
            in_ch.data_byte <= body_bytes[0].data;
            offered         <= body_bytes[0];
            do @(posedge i_clk); while (!in_ch.ready);
            void'(body_bytes.pop_front());
            burst_left--;
        end
        in_ch.valid <= 1'b0;
    endtask

    task automatic settle();
        do @(posedge i_clk); while (due_decodes.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_limit(input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_MAX_BODY;
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        m_limit = value;
        pwrite  <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        check_field("max_body_size", m_limit, prdata);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    always @(posedge i_clk) begin
        if (stall_left == 0) begin
            stall_mode = t_drain'($urandom_range(DRAIN_SLOW));
            stall_left = $urandom_range(20, 120);
        end
        stall_left--;
        case (stall_mode)
            DRAIN_FREE:   out_ch.ready <= 1'b1;
            DRAIN_COIN:   out_ch.ready <= 1'($urandom_range(1));
            DRAIN_SPARSE: out_ch.ready <= (stall_left % 5) != 0;
            default:      out_ch.ready <= (stall_left % 12) < 3;
        endcase
    end

    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        logic    moved;
        if (i_rst_n) begin
            moved = 1'b0;
            if (in_ch.valid && in_ch.ready) begin
                want = decode_byte(offered.data);
                due_decodes = {due_decodes, (offered.fixed ? offered.result : want)};
                bytes_in++;
                moved = 1'b1;
            end
            if (out_ch.valid && out_ch.ready) begin
                got = '{out_ch.payload_valid, out_ch.payload_byte, out_ch.body_done,
                        out_ch.status};
                results_out++;
                moved = 1'b1;
                if (got.pv) payload_out++;
                if (due_decodes.size() == 0) begin
                    $error("result word with no byte pending: %p", got);
                    failures++;
                end else begin
                    want = due_decodes.pop_front();
                    check_field("payload_valid", want.pv, got.pv);
                    check_field("payload_byte", want.pbyte, got.pbyte);
                    check_field("body_done", want.done, got.done);
                    check_field("status", want.status, got.status);
                end
            end
            idle_cycles = moved ? 0 : idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("FAILURE");
                $finish;
            end
        end
    end

    initial begin
        i_rst_n         <= 1'b0;
        psel            <= 1'b0;
        penable         <= 1'b0;
        pwrite          <= 1'b0;
        paddr           <= '0;
        pwdata          <= '0;
        in_ch.valid     <= 1'b0;
        in_ch.data_byte <= '0;
        offered         <= '0;

        m_phase       = PH_SIZE;
        m_remaining   = '0;
        m_count       = '0;
        m_digits      = 0;
        m_trail_empty = 1'b1;
        m_err         = ST_OK;
        m_limit       = MAX_BODY_RESET;
        ending        = t_ending'($urandom_range(END_TOO_LARGE));

        // Eight-digit size with leading zeros, payload extremes, and a payload CR.
        directed_rows = '{
            fixed_row(8'h30, 1'b0), fixed_row(8'h30, 1'b0), fixed_row(8'h30, 1'b0),
            fixed_row(8'h30, 1'b0), fixed_row(8'h30, 1'b0), fixed_row(8'h30, 1'b0),
            fixed_row(8'h30, 1'b0), fixed_row(8'h32, 1'b0),
            fixed_row(CH_CR, 1'b0), fixed_row(CH_LF, 1'b0),
            fixed_row(8'h00, 1'b1), fixed_row(8'hFF, 1'b1),
            fixed_row(CH_CR, 1'b0), fixed_row(CH_LF, 1'b0),
            fixed_row(8'h31, 1'b0), fixed_row(CH_CR, 1'b0), fixed_row(CH_LF, 1'b0),
            fixed_row(CH_CR, 1'b1),
            fixed_row(CH_CR, 1'b0), fixed_row(CH_LF, 1'b0)
        };

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_rows[i]) body_bytes = {body_bytes, directed_rows[i]};
        drive_plan();
        settle();

        write_limit(32'hFFFF_FFFF);
        plan_random_body(RANDOM_PER_PHASE);
        drive_plan();
        settle();

        write_limit(m_count + 32'($urandom_range(1000, 1 << 20)));
        plan_random_body(RANDOM_PER_PHASE);
        drive_plan();
        settle();

        write_limit(32'h0);
        plan_ending();
        drive_plan();
        settle();

        $display("Checked %0d result words for %0d body bytes, %0d payload bytes in %0d chunks.",
                 results_out, bytes_in, payload_out, chunks_planned);
        $display("Size limits went from reset to all ones, mid range and zero; end case %s.",
                 ending.name());
        if (failures == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
